>>> src/slc_pkg.sv
package slc_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] mode_t;

  localparam op_t OP_CLOCK    = 2'd0;
  localparam op_t OP_DESELECT = 2'd1;
  localparam op_t OP_RESET    = 2'd2;
  localparam op_t OP_READ     = 2'd3;

  localparam mode_t MODE_BLANK  = 2'd0;
  localparam mode_t MODE_ALL_ON = 2'd1;
  localparam mode_t MODE_RAM    = 2'd2;

  localparam logic [7:0] CMD_FSET_MASK = 8'hF8;
  localparam logic [7:0] CMD_FSET      = 8'h20;
  localparam logic [7:0] CMD_DCTL_MASK = 8'hFA;
  localparam logic [7:0] CMD_DCTL      = 8'h08;
  localparam logic [7:0] CMD_BANK_MASK = 8'hF8;
  localparam logic [7:0] CMD_BANK      = 8'h40;
  localparam logic [7:0] CMD_COL_BIT   = 8'h80;
  localparam logic [7:0] CMD_COL_MASK  = 8'h7F;
  localparam logic [7:0] CMD_BANK_SEL  = 8'h07;
  localparam logic [7:0] CMD_FLAG_BIT2 = 8'h04;

  localparam logic [7:0] PIXELS_ON  = 8'hFF;
  localparam logic [7:0] PIXELS_OFF = 8'h00;

  typedef struct packed {
    mode_t      mode;
    logic       power_down;
    logic       extended_set;
    logic [6:0] column;
    logic [2:0] bank;
  } status_t;

  typedef struct packed {
    logic       en;
    logic [2:0] bank;
    logic [6:0] column;
    logic [7:0] data;
  } ram_wr_t;

endpackage

>>> src/slc_req_if.sv
interface slc_req_if;
  import slc_pkg::*;

  logic       valid;
  logic       ready;
  op_t        op;
  logic       din;
  logic       dc;
  logic [2:0] read_bank;
  logic [6:0] read_column;

  modport source (output valid, op, din, dc, read_bank, read_column, input ready);
  modport sink (input valid, op, din, dc, read_bank, read_column, output ready);
endinterface

>>> src/slc_rsp_if.sv
interface slc_rsp_if;
  import slc_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] shown_byte;
  mode_t      display_mode;
  logic       power_down;
  logic       extended_set;
  logic [6:0] column_pointer;
  logic [2:0] bank_pointer;

  modport source (output valid, shown_byte, display_mode, power_down, extended_set,
                  column_pointer, bank_pointer, input ready);
  modport sink (input valid, shown_byte, display_mode, power_down, extended_set,
                column_pointer, bank_pointer, output ready);
endinterface

>>> src/slc_ctrl.sv
module slc_ctrl #(
  parameter int COLUMNS = 84,
  parameter int BANKS   = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  slc_pkg::op_t      op,
  input  logic              din,
  input  logic              dc,
  output slc_pkg::status_t  nxt,
  output slc_pkg::ram_wr_t  wr
);
  import slc_pkg::*;

  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bit_count, bit_count_next;
  logic [6:0] column, column_next;
  logic [2:0] bank, bank_next;
  logic       powered_down, powered_down_next;
  logic       extended_flag, extended_flag_next;
  logic       d_bit, d_bit_next;
  logic       e_bit, e_bit_next;

  logic [7:0] byte_now;
  logic [7:0] column_inc;
  logic [3:0] bank_inc;

  assign byte_now   = {shift_byte[7:1], din};
  assign column_inc = {1'b0, column} + 8'd1;
  assign bank_inc   = {1'b0, bank} + 4'd1;

  always_comb begin
    shift_byte_next    = shift_byte;
    bit_count_next     = bit_count;
    column_next        = column;
    bank_next          = bank;
    powered_down_next  = powered_down;
    extended_flag_next = extended_flag;
    d_bit_next         = d_bit;
    e_bit_next         = e_bit;
    wr                 = '0;
    unique case (op)
      OP_CLOCK: begin
        if (bit_count == 3'd7) begin
          shift_byte_next = byte_now;
          bit_count_next  = 3'd0;
          if (dc) begin
            // write only when the request is actually taken
            wr.en     = step;
            wr.bank   = bank;
            wr.column = column;
            wr.data   = byte_now;
            // advance horizontally, wrap into the next bank, then to bank 0
            if (column_inc >= 8'(COLUMNS)) begin
              column_next = 7'd0;
              bank_next   = (bank_inc >= 4'(BANKS)) ? 3'd0 : bank_inc[2:0];
            end else begin
              column_next = column_inc[6:0];
            end
          end else begin
            priority if ((byte_now & CMD_FSET_MASK) == CMD_FSET) begin
              extended_flag_next = byte_now[0];
              powered_down_next  = |(byte_now & CMD_FLAG_BIT2);
            end else if (extended_flag) begin
              // basic commands are dropped in the extended set
            end else if ((byte_now & CMD_DCTL_MASK) == CMD_DCTL) begin
              d_bit_next = |(byte_now & CMD_FLAG_BIT2);
              e_bit_next = byte_now[0];
            end else if ((byte_now & CMD_BANK_MASK) == CMD_BANK) begin
              if ({1'b0, byte_now[2:0]} < 4'(BANKS)) begin
                bank_next = byte_now[2:0];
              end
            end else if ((byte_now & CMD_COL_BIT) == CMD_COL_BIT) begin
              if ({1'b0, byte_now[6:0]} < 8'(COLUMNS)) begin
                column_next = byte_now[6:0];
              end
            end
          end
        end else begin
          shift_byte_next = {byte_now[6:0], 1'b0};
          bit_count_next  = bit_count + 3'd1;
        end
      end
      OP_DESELECT: begin
        shift_byte_next = 8'd0;
        bit_count_next  = 3'd0;
      end
      OP_RESET: begin
        shift_byte_next    = 8'd0;
        bit_count_next     = 3'd0;
        column_next        = 7'd0;
        bank_next          = 3'd0;
        powered_down_next  = 1'b1;
        extended_flag_next = 1'b0;
        d_bit_next         = 1'b0;
        e_bit_next         = 1'b0;
      end
      OP_READ: begin
      end
      default: begin
      end
    endcase

    nxt.mode         = d_bit_next ? MODE_RAM : (e_bit_next ? MODE_ALL_ON : MODE_BLANK);
    nxt.power_down   = powered_down_next;
    nxt.extended_set = extended_flag_next;
    nxt.column       = column_next;
    nxt.bank         = bank_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte    <= 8'd0;
      bit_count     <= 3'd0;
      column        <= 7'd0;
      bank          <= 3'd0;
      powered_down  <= 1'b1;
      extended_flag <= 1'b0;
      d_bit         <= 1'b0;
      e_bit         <= 1'b0;
    end else if (step) begin
      shift_byte    <= shift_byte_next;
      bit_count     <= bit_count_next;
      column        <= column_next;
      bank          <= bank_next;
      powered_down  <= powered_down_next;
      extended_flag <= extended_flag_next;
      d_bit         <= d_bit_next;
      e_bit         <= e_bit_next;
    end
  end

endmodule

>>> src/slc_ram.sv
module slc_ram #(
  parameter int COLUMNS = 84,
  parameter int BANKS   = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  slc_pkg::ram_wr_t  wr,
  input  logic              rd_en,
  input  logic [2:0]        rd_bank,
  input  logic [6:0]        rd_column,
  output logic [7:0]        rd_data,
  output logic              busy
);
  import slc_pkg::*;

  localparam int Depth = COLUMNS * BANKS;
  localparam int AddrW = $clog2(Depth);
  localparam int SumW  = $clog2(8 * COLUMNS + 128);

  logic [7:0]       mem [Depth];
  logic [AddrW-1:0] clr_addr;
  logic [SumW-1:0]  wr_sum, rd_sum;

  assign wr_sum = SumW'(wr.bank) * SumW'(COLUMNS) + SumW'(wr.column);
  assign rd_sum = SumW'(rd_bank) * SumW'(COLUMNS) + SumW'(rd_column);

  // sweep zeros through every cell after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AddrW'(Depth - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 8'd0;
    end else if (wr.en) begin
      mem[wr_sum[AddrW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_sum[AddrW-1:0]];
    end
  end

endmodule

>>> src/serial_lcd_controller.sv
// Serial LCD controller: takes one request per cycle (serial clock edge, deselect,
// soft reset or display read) and returns one response per request, in the cycle
// after acceptance, through a single output register. While a response waits
// for its ready, no new request is taken; a new request is taken in the same
// cycle that the waiting response leaves. After rst the display RAM is swept to
// zero one cell a cycle, all COLUMNS*BANKS cells (504 by default), and no request is
// taken until the sweep ends. The RAM has one write port and one registered read
// port; soft reset requests keep its contents.
module serial_lcd_controller #(
  parameter int COLUMNS = 84,
  parameter int BANKS   = 6
) (
  input logic       clk,
  input logic       rst,
  slc_req_if.sink   req,
  slc_rsp_if.source rsp
);
  import slc_pkg::*;

  logic       step;
  logic       busy;
  logic       hit;
  status_t    nxt;
  ram_wr_t    wr;
  logic [7:0] rd_data;

  logic       res_valid;
  logic       res_hit;
  status_t    res_status;

  assign req.ready = !busy && (!res_valid || rsp.ready);
  assign step      = req.valid && req.ready;
  assign hit       = (req.op == OP_READ) && ({1'b0, req.read_bank} < 4'(BANKS))
                     && ({1'b0, req.read_column} < 8'(COLUMNS));

  slc_ctrl #(.COLUMNS(COLUMNS), .BANKS(BANKS)) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .op   (req.op),
    .din  (req.din),
    .dc   (req.dc),
    .nxt  (nxt),
    .wr   (wr)
  );

  slc_ram #(.COLUMNS(COLUMNS), .BANKS(BANKS)) u_ram (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd_en     (step && hit),
    .rd_bank   (req.read_bank),
    .rd_column (req.read_column),
    .rd_data   (rd_data),
    .busy      (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_status <= nxt;
      res_hit    <= hit;
    end
  end

  always_comb begin
    rsp.shown_byte = PIXELS_OFF;
    if (res_hit) begin
      unique case (res_status.mode)
        MODE_RAM:    rsp.shown_byte = rd_data;
        MODE_ALL_ON: rsp.shown_byte = PIXELS_ON;
        default:     rsp.shown_byte = PIXELS_OFF;
      endcase
    end
  end

  assign rsp.valid          = res_valid;
  assign rsp.display_mode   = res_status.mode;
  assign rsp.power_down     = res_status.power_down;
  assign rsp.extended_set   = res_status.extended_set;
  assign rsp.column_pointer = res_status.column;
  assign rsp.bank_pointer   = res_status.bank;

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ({1'b0, res_status.column} < 8'(COLUMNS))
                  && ({1'b0, res_status.bank} < 4'(BANKS)))
    else $error("write pointer out of range");

  a_blank_dark: assert property (@(posedge clk) disable iff (rst)
    (res_valid && rsp.shown_byte != PIXELS_OFF) |-> (res_status.mode != MODE_BLANK))
    else $error("pixels lit in blank mode");

  a_sweep_quiet: assert property (@(posedge clk) disable iff (rst)
    busy |=> !res_valid || $past(res_valid))
    else $error("response produced during RAM sweep");

  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(step))
    else $error("response without an accepted request");

endmodule

>>> tb/serial_lcd_controller_checker.sv
module serial_lcd_controller_checker #(
  parameter int COLUMNS = 84,
  parameter int BANKS   = 6
) (
  input  logic clk,
  input  logic rst,
  slc_req_if   req,
  slc_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import slc_pkg::*;

  typedef struct packed {
    logic [7:0] shown;
    status_t    status;
  } lcd_view_t;

  logic [7:0] shift_reg;
  logic [2:0] bit_cnt;
  logic [7:0] pixel_ram [BANKS*COLUMNS];
  logic [6:0] col_ptr;
  logic [2:0] bank_ptr;
  logic       pd_flag;
  logic       ext_flag;
  logic       d_bit;
  logic       e_bit;

  lcd_view_t  view_q[$];
  int         err_count = 0;

  task automatic restore_defaults();
    shift_reg = '0;
    bit_cnt   = '0;
    pd_flag   = 1'b1;
    ext_flag  = 1'b0;
    d_bit     = 1'b0;
    e_bit     = 1'b0;
    col_ptr   = '0;
    bank_ptr  = '0;
  endtask

  task automatic apply_command(input logic [7:0] c);
    if ((c & CMD_FSET_MASK) == CMD_FSET) begin
      ext_flag = c[0];
      pd_flag  = (c & CMD_FLAG_BIT2) != 8'h00;
    end else if (!ext_flag) begin
      if ((c & CMD_DCTL_MASK) == CMD_DCTL) begin
        d_bit = (c & CMD_FLAG_BIT2) != 8'h00;
        e_bit = c[0];
      end else if ((c & CMD_BANK_MASK) == CMD_BANK) begin
        if (int'(c & CMD_BANK_SEL) < BANKS) bank_ptr = c[2:0];
      end else if ((c & CMD_COL_BIT) != 8'h00) begin
        if (int'(c & CMD_COL_MASK) < COLUMNS) col_ptr = c[6:0];
      end
    end
  endtask

  task automatic take_serial_bit(input logic din, input logic dc);
    shift_reg[0] = din;
    if (bit_cnt == 3'd7) begin
      if (dc) begin
        pixel_ram[int'(bank_ptr) * COLUMNS + int'(col_ptr)] = shift_reg;
        // advance horizontally, wrap into the next bank, then back to bank 0
        if (int'(col_ptr) + 1 >= COLUMNS) begin
          col_ptr = '0;
          bank_ptr = bank_ptr + 3'd1;
        end else begin
          col_ptr = col_ptr + 7'd1;
        end
        if (int'(bank_ptr) >= BANKS) bank_ptr = '0;
      end else begin
        apply_command(shift_reg);
      end
      bit_cnt = '0;
    end else begin
      shift_reg = shift_reg << 1;
      bit_cnt   = bit_cnt + 3'd1;
    end
  endtask

  task automatic predict_request(input op_t op, input logic din, input logic dc,
                                 input logic [2:0] rb, input logic [6:0] rc);
    lcd_view_t view;
    mode_t     mode;
    case (op)
      OP_CLOCK:    take_serial_bit(din, dc);
      OP_DESELECT: begin
        shift_reg = '0;
        bit_cnt   = '0;
      end
      OP_RESET:    restore_defaults();
      default:     ;
    endcase
    mode = d_bit ? MODE_RAM : (e_bit ? MODE_ALL_ON : MODE_BLANK);
    view.shown = PIXELS_OFF;
    if (op == OP_READ && int'(rb) < BANKS && int'(rc) < COLUMNS) begin
      case (mode)
        MODE_RAM:    view.shown = pixel_ram[int'(rb) * COLUMNS + int'(rc)];
        MODE_ALL_ON: view.shown = PIXELS_ON;
        default:     view.shown = PIXELS_OFF;
      endcase
    end
    view.status.mode         = mode;
    view.status.power_down   = pd_flag;
    view.status.extended_set = ext_flag;
    view.status.column       = col_ptr;
    view.status.bank         = bank_ptr;
    view_q.push_back(view);
  endtask

  always @(posedge clk) begin
    lcd_view_t want;
    if (rst) begin
      restore_defaults();
      foreach (pixel_ram[i]) pixel_ram[i] = 8'h00;
      view_q.delete();
    end else begin
      if (req.valid && req.ready)
        predict_request(req.op, req.din, req.dc, req.read_bank, req.read_column);
      if (rsp.valid && rsp.ready) begin
        if (view_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: response with no request outstanding", $realtime);
        end else begin
          want = view_q.pop_front();
          if (rsp.shown_byte !== want.shown ||
              rsp.display_mode !== want.status.mode ||
              rsp.power_down !== want.status.power_down ||
              rsp.extended_set !== want.status.extended_set ||
              rsp.column_pointer !== want.status.column ||
              rsp.bank_pointer !== want.status.bank) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: mismatch (exp/got) shown %02h/%02h mode %0d/%0d pd %0b/%0b",
                        " ext %0b/%0b col %0d/%0d bank %0d/%0d"}, $realtime,
                       want.shown, rsp.shown_byte, want.status.mode, rsp.display_mode,
                       want.status.power_down, rsp.power_down,
                       want.status.extended_set, rsp.extended_set,
                       want.status.column, rsp.column_pointer,
                       want.status.bank, rsp.bank_pointer);
          end
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= view_q.size();
  end

endmodule

>>> tb/serial_lcd_controller_tb.sv
module serial_lcd_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slc_pkg::*;

  localparam int LCD_COLUMNS = 84;
  localparam int LCD_BANKS   = 6;
  localparam int ITEM_TARGET = 1150;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;

  bit   calm = 1'b0;
  int   stall_left = 0;
  int   items_sent = 0;
  int   data_bytes = 0;
  int   cmd_bytes = 0;
  int   reads_sent = 0;
  int   breaks_sent = 0;

  slc_req_if req_bus ();
  slc_rsp_if rsp_bus ();

  serial_lcd_controller #(
    .COLUMNS(LCD_COLUMNS),
    .BANKS  (LCD_BANKS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  serial_lcd_controller_checker #(
    .COLUMNS(LCD_COLUMNS),
    .BANKS  (LCD_BANKS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // response side: random stall bursts, none once the run calms down
  always @(posedge clk) begin
    if (calm) begin
      stall_left <= 0;
      rsp_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  task automatic send_item(input op_t op, input logic din, input logic dc,
                           input logic [2:0] rb, input logic [6:0] rc);
    if (!calm && $urandom_range(0, 11) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.op          <= op;
    req_bus.din         <= din;
    req_bus.dc          <= dc;
    req_bus.read_bank   <= rb;
    req_bus.read_column <= rc;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] value, input logic dc);
    for (int i = 7; i >= 0; i--)
      send_item(OP_CLOCK, value[i], dc, 3'($urandom_range(0, 7)),
                7'($urandom_range(0, 127)));
    if (dc) data_bytes++;
    else cmd_bytes++;
  endtask

  task automatic read_cell(input logic [2:0] rb, input logic [6:0] rc);
    send_item(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rb, rc);
    reads_sent++;
  endtask

  task automatic send_control(input op_t op);
    send_item(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
    breaks_sent++;
  endtask

  task automatic drain_responses();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [7:0] pick_command();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: begin
        c = CMD_FSET | 8'($urandom_range(0, 7));
        c[0] = ($urandom_range(0, 3) == 0);
      end
      1: begin
        c = CMD_DCTL | 8'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) c = c | CMD_FLAG_BIT2;
      end
      2: c = CMD_BANK | 8'($urandom_range(0, 7));
      3: c = CMD_COL_BIT | 8'($urandom_range(0, 1) ? $urandom_range(0, 127)
                                                   : $urandom_range(80, 83));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  initial begin
    bit drained_mid;
    int guard;
    drained_mid = 1'b0;
    rst <= 1'b1;
    req_bus.valid       <= 1'b0;
    req_bus.op          <= OP_CLOCK;
    req_bus.din         <= 1'b0;
    req_bus.dc          <= 1'b0;
    req_bus.read_bank   <= '0;
    req_bus.read_column <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: power-up reads, out-of-range cells, deselect, soft reset,
    // then show RAM, write one byte and read it back, plus out-of-range reads
    read_cell(3'd0, 7'd0);
    read_cell(3'd7, 7'd127);
    send_control(OP_DESELECT);
    send_control(OP_RESET);
    send_byte(CMD_DCTL | CMD_FLAG_BIT2, 1'b0);
    send_byte(8'hA5, 1'b1);
    read_cell(3'd0, 7'd0);
    read_cell(3'(LCD_BANKS), 7'd0);
    read_cell(3'd0, 7'(LCD_COLUMNS));
    drain_responses();

    while (items_sent < ITEM_TARGET) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 55) begin
        send_byte(pick_command(), 1'b0);
      end else if (r < 85) begin
        if ($urandom_range(0, 5) == 0)
          read_cell(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        else
          read_cell(3'($urandom_range(0, LCD_BANKS - 1)),
                    7'($urandom_range(0, LCD_COLUMNS - 1)));
      end else if (r < 89) begin
        // broken byte, usually dropped by a deselect
        repeat ($urandom_range(1, 7))
          send_item(OP_CLOCK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        if ($urandom_range(0, 3) != 0) send_control(OP_DESELECT);
      end else if (r < 93) begin
        send_control(OP_DESELECT);
      end else if (r < 95) begin
        send_control(OP_RESET);
      end else begin
        send_item(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  7'($urandom_range(0, 127)));
        send_control(OP_DESELECT);
      end
      if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
        drained_mid = 1'b1;
        drain_responses();
      end
      if (items_sent >= ITEM_TARGET - 150) calm = 1'b1;
    end

    req_bus.valid <= 1'b0;
    guard = 0;
    while (outstanding != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d requests: %0d data bytes, %0d command bytes, %0d reads,",
             items_sent, data_bytes, cmd_bytes, reads_sent);
    $display("and %0d deselect/soft-reset requests, with stalls on both sides.", breaks_sent);
    if (outstanding != 0)
      $display("%0d expected responses never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
